// ===== hdl/rtpg_pkg.sv =====
// Package with codes, types and helpers shared by the RTP L16 receive path.
`timescale 1ns / 1ps
`default_nettype none

package rtpg_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic        PLAYING_RST = 1'b0;
    localparam logic [6:0]  TYPE_RST    = 7'd96;
    localparam logic [1:0]  CHAN_RST    = 2'd2;
    localparam logic [15:0] GAIN_RST    = 16'h8000;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED    = 2'd0,
        ST_NOT_PLAYING = 2'd1,
        ST_BAD_TYPE    = 2'd2,
        ST_BAD_LENGTH  = 2'd3
    } status_t;

    typedef enum logic {
        RK_STATUS = 1'b0,
        RK_SAMPLE = 1'b1
    } rkind_t;

    typedef enum logic [1:0] {
        REG_PLAYING = 2'd0,
        REG_TYPE    = 2'd1,
        REG_CHANNEL = 2'd2,
        REG_GAIN    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic               result_kind;
        logic [1:0]         status;
        logic signed [15:0] sample_out;
        logic               last_sample;
        logic [15:0]        packet_peak;
        logic [31:0]        received_count;
        logic [31:0]        lost_count;
        logic [31:0]        nonzero_count;
    } result_t;

    // Divisibility by three: fold base-4 digits, since 4 = 1 mod 3.
    function automatic logic div3(input logic [15:0] x);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 5'(x[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        return (s3 == 3'd0) || (s3 == 3'd3);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rtpg_scale.sv =====
// Sample gain stage: Q1.15 multiply, truncate toward zero, saturate, magnitude.
`timescale 1ns / 1ps
`default_nettype none

module rtpg_scale (
    input  wire logic signed [15:0] sample,
    input  wire logic [15:0]        gain,
    output logic signed [15:0]      scaled,
    output logic [15:0]             magnitude
);

    logic signed [32:0] prod;
    logic signed [32:0] biased;
    logic signed [17:0] quot;

    assign prod = 33'(sample) * 33'($signed({1'b0, gain}));

    // Bias negatives so the arithmetic shift rounds toward zero.
    assign biased = prod[32] ? (prod + 33'sd32767) : prod;
    assign quot   = biased[32:15];

    always_comb begin
        if (quot[17:15] == 3'b000 || quot[17:15] == 3'b111) begin
            scaled = quot[15:0];
        end else if (quot[17]) begin
            scaled = 16'sh8000;
        end else begin
            scaled = 16'sh7FFF;
        end
    end

    assign magnitude = sample[15] ? (16'd0 - sample) : sample;

endmodule

`default_nettype wire

// ===== hdl/rtp_l16_receive_gain_unit.sv =====
// Top level of the RTP L16 receive path with loss counting and sample gain.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+-------------------
// input    | s_kind, s_sequence_number, s_packet_type,    | s_valid / s_ready
//          | s_payload_bytes, s_byte_pair                 |
// result   | m_result_kind, m_status, m_sample_out, ...   | m_valid / m_ready
// config   | cfg_we, cfg_addr, cfg_wdata                  | write on cfg_we
//
// One item per cycle while s_ready is high: each item is decoded, scaled and
// counted in the cycle it is accepted; any result is registered into the head
// of a two-entry output buffer, or into skid while the head stalls. The output
// buffer sets the rate under backpressure: s_ready drops only when both entries
// hold a result. Reset (aresetn low, synchronous) clears counters, packet state
// and buffer and loads the register defaults. No clearing pass is needed.

module rtp_l16_receive_gain_unit #(
    parameter int MAX_SAMPLES = rtpg_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_kind,
    input  wire logic [15:0]                     s_sequence_number,
    input  wire logic [6:0]                      s_packet_type,
    input  wire logic [15:0]                     s_payload_bytes,
    input  wire logic [15:0]                     s_byte_pair,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_result_kind,
    output logic [1:0]                           m_status,
    output logic signed [15:0]                   m_sample_out,
    output logic                                 m_last_sample,
    output logic [15:0]                          m_packet_peak,
    output logic [31:0]                          m_received_count,
    output logic [31:0]                          m_lost_count,
    output logic [31:0]                          m_nonzero_count,

    input  wire logic                            cfg_we,
    input  wire logic [rtpg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [rtpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int          LEFT_W  = $clog2(MAX_SAMPLES + 1);
    localparam logic [14:0] MAX_CNT = 15'(MAX_SAMPLES);

    // Session registers.
    logic        playing_reg;
    logic [6:0]  exp_type_reg;
    logic [1:0]  chan_reg;
    logic [15:0] gain_reg;

    // Stream state.
    logic [15:0]       last_seq_reg,  last_seq_next;
    logic [31:0]       recv_reg,      recv_next;
    logic [31:0]       lost_reg,      lost_next;
    logic [31:0]       nonzero_reg,   nonzero_next;
    logic              open_reg,      open_next;
    logic [LEFT_W-1:0] left_reg,      left_next;
    logic [15:0]       peak_reg,      peak_next;

    // Output buffer: head drives the ports, skid catches one more result.
    rtpg_pkg::result_t head_reg, skid_reg, res;
    logic              head_valid_reg, skid_valid_reg;

    logic              accept;
    logic              push;
    logic              pop;
    logic signed [15:0] scaled;
    logic [15:0]       mag;
    logic [15:0]       peak_upd;
    logic [15:0]       seq_diff;
    logic              bad_len;
    logic [14:0]       half;
    logic [14:0]       count;

    rtpg_scale u_scale (
        .sample    (s_byte_pair),
        .gain      (gain_reg),
        .scaled    (scaled),
        .magnitude (mag)
    );

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = head_valid_reg && m_ready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg  <= rtpg_pkg::PLAYING_RST;
            exp_type_reg <= rtpg_pkg::TYPE_RST;
            chan_reg     <= rtpg_pkg::CHAN_RST;
            gain_reg     <= rtpg_pkg::GAIN_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                rtpg_pkg::REG_PLAYING: playing_reg  <= cfg_wdata[0];
                rtpg_pkg::REG_TYPE:    exp_type_reg <= cfg_wdata[6:0];
                rtpg_pkg::REG_CHANNEL: chan_reg     <= cfg_wdata[1:0];
                rtpg_pkg::REG_GAIN:    gain_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Length check: payload must be a whole number of frames of 2*channels bytes.
    always_comb begin
        case (chan_reg)
            2'd1:    bad_len = s_payload_bytes[0];
            2'd2:    bad_len = (s_payload_bytes[1:0] != 2'b00);
            2'd3:    bad_len = s_payload_bytes[0] || !rtpg_pkg::div3(s_payload_bytes);
            default: bad_len = 1'b1;
        endcase
    end

    assign half     = s_payload_bytes[15:1];
    assign count    = (half > MAX_CNT) ? MAX_CNT : half;
    assign seq_diff = s_sequence_number - (last_seq_reg + 16'd1);
    assign peak_upd = (mag > peak_reg) ? mag : peak_reg;

    always_comb begin
        last_seq_next = last_seq_reg;
        recv_next     = recv_reg;
        lost_next     = lost_reg;
        nonzero_next  = nonzero_reg;
        open_next     = open_reg;
        left_next     = left_reg;
        peak_next     = peak_reg;
        push          = 1'b0;
        res           = '0;

        if (accept) begin
            case (s_kind)
                rtpg_pkg::KIND_CLEAR: begin
                    recv_next    = '0;
                    lost_next    = '0;
                    nonzero_next = '0;
                end
                rtpg_pkg::KIND_HEADER: begin
                    // Any header closes an open packet silently.
                    open_next       = 1'b0;
                    left_next       = '0;
                    peak_next       = '0;
                    push            = 1'b1;
                    res.result_kind = rtpg_pkg::RK_STATUS;
                    if (!playing_reg) begin
                        res.status = rtpg_pkg::ST_NOT_PLAYING;
                    end else if (s_packet_type != exp_type_reg) begin
                        res.status = rtpg_pkg::ST_BAD_TYPE;
                    end else begin
                        // Count only forward gaps, and only after a first packet.
                        if (recv_reg != 32'd0 && seq_diff != 16'd0 && !seq_diff[15]) begin
                            lost_next = lost_reg + 32'(seq_diff);
                        end
                        last_seq_next = s_sequence_number;
                        recv_next     = recv_reg + 32'd1;
                        if (bad_len) begin
                            res.status = rtpg_pkg::ST_BAD_LENGTH;
                        end else begin
                            res.status = rtpg_pkg::ST_ACCEPTED;
                            if (count != 15'd0) begin
                                open_next = 1'b1;
                                left_next = LEFT_W'(count);
                            end
                        end
                    end
                end
                rtpg_pkg::KIND_SAMPLE: begin
                    // Drop words that arrive with no packet open.
                    if (open_reg && left_reg != '0) begin
                        push            = 1'b1;
                        res.result_kind = rtpg_pkg::RK_SAMPLE;
                        res.status      = rtpg_pkg::ST_ACCEPTED;
                        res.sample_out  = scaled;
                        left_next       = left_reg - LEFT_W'(1);
                        if (left_reg == LEFT_W'(1)) begin
                            res.last_sample   = 1'b1;
                            res.packet_peak   = peak_upd;
                            open_next         = 1'b0;
                            peak_next         = '0;
                            if (peak_upd != 16'd0) begin
                                nonzero_next = nonzero_reg + 32'd1;
                            end
                        end else begin
                            peak_next = peak_upd;
                        end
                    end
                end
                default: ;
            endcase
        end

        res.received_count = recv_next;
        res.lost_count     = lost_next;
        res.nonzero_count  = nonzero_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg <= '0;
            recv_reg     <= '0;
            lost_reg     <= '0;
            nonzero_reg  <= '0;
            open_reg     <= 1'b0;
            left_reg     <= '0;
            peak_reg     <= '0;
        end else begin
            last_seq_reg <= last_seq_next;
            recv_reg     <= recv_next;
            lost_reg     <= lost_next;
            nonzero_reg  <= nonzero_next;
            open_reg     <= open_next;
            left_reg     <= left_next;
            peak_reg     <= peak_next;
        end
    end

    // Output buffer control: fill head first, spill into skid while head stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            head_valid_reg <= 1'b0;
        end
    end

    // Output buffer payload.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                head_reg <= skid_reg;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_valid          = head_valid_reg;
    assign m_result_kind    = head_reg.result_kind;
    assign m_status         = head_reg.status;
    assign m_sample_out     = head_reg.sample_out;
    assign m_last_sample    = head_reg.last_sample;
    assign m_packet_peak    = head_reg.packet_peak;
    assign m_received_count = head_reg.received_count;
    assign m_lost_count     = head_reg.lost_count;
    assign m_nonzero_count  = head_reg.nonzero_count;

    // The skid entry is never filled while the head is empty.
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with empty head");

    // An open packet always has samples due, a closed one none.
    a_open_matches_left: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg == (left_reg != '0))
        else $error("packet open flag disagrees with sample count");

    a_left_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= LEFT_W'(MAX_SAMPLES))
        else $error("sample count beyond limit");

    // Peak tracking restarts with every packet.
    a_peak_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> (peak_reg == 16'd0))
        else $error("peak held with no packet open");

    // m_valid is high in the cycle after an item that produces a result.
    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid)
        else $error("result lost after accept");

endmodule

`default_nettype wire
